// ----- hdl/breakpoint_table_top_macros.svh -----
// Assertion macros for the breakpoint table.
// Used by breakpoint_table_top; relies on clk and rst_n in the including scope.
`ifndef BREAKPOINT_TABLE_TOP_MACROS_SVH
`define BREAKPOINT_TABLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define BPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define BPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BPT_ASSERT_NOW(label, ante, cons, msg)
`define BPT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hdl/bpt_pkg.sv -----
// Shared types, sizes and codes for the breakpoint table.
// No dependencies; imported by every module of the block.
`default_nettype none

package bpt_pkg;

    // Table sizing
    localparam int ENTRIES   = 32;
    localparam int ADDR_BITS = 16;
    localparam int IN_ADDR_W = 16;
    localparam int KEY_W     = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

    // Command codes
    typedef enum logic [2:0] {
        CMD_SET_PERM = 3'd0,
        CMD_SET_TEMP = 3'd1,
        CMD_DELETE   = 3'd2,
        CMD_CLEAR    = 3'd3,
        CMD_CHECK    = 3'd4
    } cmd_t;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Channel payloads
    typedef struct packed {
        logic [2:0]           cmd;
        logic [IN_ADDR_W-1:0] address;
    } cmd_item_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
        logic [5:0] entry_count;
    } rsp_item_t;

    // One table entry
    typedef struct packed {
        logic [KEY_W-1:0] addr;
        logic             temp;
    } entry_t;

    // Memory access request from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- hdl/breakpoint_table_top.sv -----
// A clear, full or unknown command finishes without touching the entry store; any other
// command runs the ordered search, reading entries until one is not below the key or the
// end is reached, then an insert or remove moves entries one at a time by a read and a write.
// Throughput: one item at a time through the entry store; the result
// register frees the input side while a result waits downstream.
// Reset (rst_n, asynchronous) empties the table at once; entry contents are not cleared.
`default_nettype none

`include "breakpoint_table_top_macros.svh"

module breakpoint_table_top
    import bpt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire cmd_item_t cmd_item,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_item_t      rsp_item
);

    mem_req_t         mem_req;
    entry_t           rd_data;
    logic [CNT_W-1:0] count;

    // Entry store
    bpt_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Sequencer
    bpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .count     (count)
    );

    // Checks
    `BPT_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "accepted item did not busy the block")
    `BPT_ASSERT_NOW(a_count_in_range, 1'b1, count <= ENTRIES_C, "entry count beyond table size")
    `BPT_ASSERT_NOW(a_hit_ok, rsp_valid && rsp_item.hit, rsp_item.status == ST_OK, "hit with error status")
    `BPT_ASSERT_NOW(a_one_port, mem_req.we, !mem_req.re, "read and write in one cycle")

endmodule

`default_nettype wire

// ----- hdl/bpt_ram.sv -----
// Entry store: one write port, one read port, registered read data.
// Depends on bpt_pkg for entry and request types.
`default_nettype none

module bpt_ram
    import bpt_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_req_t req,
    output entry_t        rd_data
);

    entry_t mem_array [ENTRIES];
    entry_t rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem_array[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/bpt_ctrl.sv -----
// Sequencer: ordered search, insert and remove shifts, result register.
// Depends on bpt_pkg; drives the entry store in bpt_ram.
`default_nettype none

module bpt_ctrl
    import bpt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire cmd_item_t  cmd_item,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output rsp_item_t       rsp_item,
    output mem_req_t        mem_req,
    input  wire entry_t     rd_data,
    output logic [CNT_W-1:0] count
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RD     = 8'b0000_0010,
        S_CMP    = 8'b0000_0100,
        S_ACT    = 8'b0000_1000,
        S_UP     = 8'b0001_0000,
        S_UP_WR  = 8'b0010_0000,
        S_DN     = 8'b0100_0000,
        S_DN_WR  = 8'b1000_0000
    } state_t;

    // S_DONE folded in: a separate flag marks a finished item waiting to load
    state_t           state_reg, state_next;
    logic             done_reg, done_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             found_reg, found_next;
    logic             ftemp_reg, ftemp_next;
    logic             hit_reg, hit_next;
    logic [1:0]       status_reg, status_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_item_t        rsp_item_reg, rsp_item_next;

    logic [CNT_W-1:0] k_dec;
    logic [CNT_W-1:0] k_inc;
    logic [CNT_W+5:0] cnt_wide;

    assign k_dec    = k_reg - CNT_W'(1);
    assign k_inc    = k_reg + CNT_W'(1);
    assign cnt_wide = {6'd0, count_reg};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        found_reg    <= found_next;
        ftemp_reg    <= ftemp_next;
        hit_reg      <= hit_next;
        status_reg   <= status_next;
        rsp_item_reg <= rsp_item_next;
    end

    // Next state and memory accesses
    always_comb
    begin
        state_next     = state_reg;
        done_next      = done_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        ftemp_next     = ftemp_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        mem_req        = '0;

        // result taken downstream
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (done_reg)
        begin
            // finished item: load the result register once it is free
            if (!rsp_valid_reg || rsp_ready)
            begin
                rsp_item_next.hit         = hit_reg;
                rsp_item_next.status      = status_reg;
                rsp_item_next.entry_count = cnt_wide[5:0];
                rsp_valid_next            = 1'b1;
                done_next                 = 1'b0;
                state_next                = S_IDLE;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_next    = cmd_item.cmd;
                        key_next    = cmd_item.address[KEY_W-1:0];
                        idx_next    = '0;
                        hit_next    = 1'b0;
                        status_next = ST_OK;
                        found_next  = 1'b0;
                        ftemp_next  = 1'b0;
                        case (cmd_item.cmd)
                            CMD_SET_PERM, CMD_SET_TEMP:
                            begin
                                if (count_reg >= ENTRIES_C)
                                begin
                                    status_next = ST_FULL;
                                    state_next  = S_ACT;
                                    done_next   = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_RD;
                                end
                            end
                            CMD_DELETE, CMD_CHECK:
                            begin
                                state_next = S_RD;
                            end
                            CMD_CLEAR:
                            begin
                                count_next = '0;
                                state_next = S_ACT;
                                done_next  = 1'b1;
                            end
                            default:
                            begin
                                state_next = S_ACT;
                                done_next  = 1'b1;
                            end
                        endcase
                    end
                end

                // issue read of the next candidate, or stop at the end
                S_RD:
                begin
                    if (idx_reg == count_reg)
                    begin
                        found_next = 1'b0;
                        state_next = S_ACT;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = idx_reg[IDX_W-1:0];
                        state_next    = S_CMP;
                    end
                end

                // first entry not below the key ends the search
                S_CMP:
                begin
                    if (rd_data.addr < key_reg)
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_RD;
                    end
                    else
                    begin
                        found_next = (rd_data.addr == key_reg);
                        ftemp_next = rd_data.temp;
                        state_next = S_ACT;
                    end
                end

                // act on the search outcome
                S_ACT:
                begin
                    case (cmd_reg)
                        CMD_SET_PERM, CMD_SET_TEMP:
                        begin
                            if (found_reg)
                            begin
                                if (cmd_reg == CMD_SET_PERM)
                                begin
                                    mem_req.we         = 1'b1;
                                    mem_req.waddr      = idx_reg[IDX_W-1:0];
                                    mem_req.wdata.addr = key_reg;
                                    mem_req.wdata.temp = 1'b0;
                                end
                                done_next = 1'b1;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                state_next = S_UP;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (found_reg)
                            begin
                                k_next     = idx_reg;
                                state_next = S_DN;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                                done_next   = 1'b1;
                            end
                        end
                        CMD_CHECK:
                        begin
                            if (found_reg)
                            begin
                                hit_next = 1'b1;
                                if (ftemp_reg)
                                begin
                                    k_next     = idx_reg;
                                    state_next = S_DN;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end

                // open a gap at the insert slot, top entry first
                S_UP:
                begin
                    if (k_reg == idx_reg)
                    begin
                        mem_req.we         = 1'b1;
                        mem_req.waddr      = idx_reg[IDX_W-1:0];
                        mem_req.wdata.addr = key_reg;
                        mem_req.wdata.temp = (cmd_reg == CMD_SET_TEMP);
                        count_next         = count_reg + CNT_W'(1);
                        done_next          = 1'b1;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = k_dec[IDX_W-1:0];
                        state_next    = S_UP_WR;
                    end
                end

                S_UP_WR:
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = k_reg[IDX_W-1:0];
                    mem_req.wdata = rd_data;
                    k_next        = k_dec;
                    state_next    = S_UP;
                end

                // close the gap at the removed slot
                S_DN:
                begin
                    if (k_inc >= count_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = k_inc[IDX_W-1:0];
                        state_next    = S_DN_WR;
                    end
                end

                S_DN_WR:
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = k_reg[IDX_W-1:0];
                    mem_req.wdata = rd_data;
                    k_next        = k_inc;
                    state_next    = S_DN;
                end

                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    assign cmd_ready = (state_reg == S_IDLE) && !done_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire
